// ----- hw/rtl/hmccs_pkg.sv -----
package hmccs_pkg;

  // Grid size: cells outside it are ignored
  localparam int unsigned GRID_COLS = 32;
  localparam int unsigned GRID_ROWS = 32;

  localparam int unsigned CoordW = 5;
  localparam int unsigned GainW  = 4;
  localparam int unsigned CostW  = 14;
  localparam int unsigned CountW = 11;
  localparam int unsigned StepW  = 2;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CostW-1:0]  CostInit = '1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_GOAL_X      = 3'd0,
    REG_GOAL_Y      = 3'd1,
    REG_CENTRE_X    = 3'd2,
    REG_CENTRE_Y    = 3'd3,
    REG_GOAL_GAIN   = 3'd4,
    REG_SMOOTH_GAIN = 3'd5,
    REG_UP_WEIGHT   = 3'd6,
    REG_DOWN_WEIGHT = 3'd7
  } reg_idx_e;

  // Occupancy class codes
  typedef enum logic [1:0] {
    OCC_EMPTY   = 2'd0,
    OCC_PARTIAL = 2'd1,
    OCC_FULL    = 2'd2
  } occ_class_e;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL_W  = 6'b000010,
    ST_MUL_G  = 6'b000100,
    ST_MUL_S  = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  function automatic logic [CoordW-1:0] absdiff(input logic [CoordW-1:0] a,
                                                input logic [CoordW-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- hw/rtl/histogram_min_cost_cell_select.sv -----
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// input     | in_valid_i / in_ready_o   | cell_x_i, cell_y_i, occupied_i, last_cell_i
// result    | out_valid_o / out_ready_i | best_x_o, best_y_o, best_cost_o, found_o,
//           |                           | occupancy_class_o
// config    | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// A free cell inside the grid passes through ST_MUL_W, ST_MUL_G, ST_MUL_S, ST_UPDATE
// and ST_FINISH: one shared shift-add unit works through the three 4-bit gain/weight
// multiplications one multiplier bit a cycle. An occupied or out-of-grid cell goes straight to ST_FINISH.
// Reset (rst_ni low, asynchronous) restores the register defaults and clears the scan.
// The result sits in an output register; a last cell whose result finds that
// register still full waits until the word there is taken.
module histogram_min_cost_cell_select
  import hmccs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [CoordW-1:0]   cfg_wdata_i,
  // cell input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CoordW-1:0]   cell_x_i,
  input  logic [CoordW-1:0]   cell_y_i,
  input  logic                occupied_i,
  input  logic                last_cell_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CoordW-1:0]   best_x_o,
  output logic [CoordW-1:0]   best_y_o,
  output logic [CostW-1:0]    best_cost_o,
  output logic                found_o,
  output logic [1:0]          occupancy_class_o
);

  localparam logic [CoordW:0] GridColsC = (CoordW+1)'(GRID_COLS);
  localparam logic [CoordW:0] GridRowsC = (CoordW+1)'(GRID_ROWS);

  // configuration registers
  logic [CoordW-1:0] goal_x_q, goal_y_q, centre_x_q, centre_y_q;
  logic [GainW-1:0]  goal_gain_q, smooth_gain_q, up_weight_q, down_weight_q;

  // scan state
  logic [CostW-1:0]  min_cost_q, min_cost_d;
  logic [CoordW-1:0] min_x_q, min_x_d, min_y_q, min_y_d;
  logic              any_free_q, any_free_d;
  logic [CountW-1:0] blocked_q, blocked_d, count_q, count_d;

  // item and arithmetic
  state_e            state_q, state_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d, dx_q, dx_d;
  logic [CoordW:0]   sxy_q, sxy_d;
  logic              last_q, last_d;
  logic [CostW-1:0]  acc_q, acc_d, mcand_q, mcand_d, step_acc;
  logic [GainW-1:0]  mplier_q, mplier_d;
  logic [StepW-1:0]  step_q, step_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [CoordW-1:0] best_x_q, best_x_d, best_y_q, best_y_d;
  logic [CostW-1:0]  best_cost_q, best_cost_d;
  logic              found_q, found_d;
  occ_class_e        class_q, class_d;

  logic              accept, in_grid, step_last;
  logic [CoordW-1:0] dy_in;
  logic [GainW-1:0]  w_in;
  occ_class_e        class_now;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign in_grid    = ({1'b0, cell_x_i} < GridColsC) && ({1'b0, cell_y_i} < GridRowsC);
  assign dy_in      = absdiff(goal_y_q, cell_y_i);
  assign w_in       = (cell_y_i >= goal_y_q) ? up_weight_q : down_weight_q;
  assign step_acc   = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
  assign step_last  = (step_q == '1);

  // classify occupancy from the counters
  always_comb begin
    priority if (blocked_q == '0) class_now = OCC_EMPTY;
    else if (blocked_q == count_q) class_now = OCC_FULL;
    else class_now = OCC_PARTIAL;
  end

  // sequence one cell through the shared shift-add unit
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    dx_d        = dx_q;
    sxy_d       = sxy_q;
    last_d      = last_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    step_d      = step_q;
    min_cost_d  = min_cost_q;
    min_x_d     = min_x_q;
    min_y_d     = min_y_q;
    any_free_d  = any_free_q;
    blocked_d   = blocked_q;
    count_d     = count_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    best_x_d    = best_x_q;
    best_y_d    = best_y_q;
    best_cost_d = best_cost_q;
    found_d     = found_q;
    class_d     = class_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_d      = cell_x_i;
          y_d      = cell_y_i;
          last_d   = last_cell_i;
          dx_d     = absdiff(goal_x_q, cell_x_i);
          sxy_d    = {1'b0, absdiff(cell_x_i, centre_x_q)}
                   + {1'b0, absdiff(cell_y_i, centre_y_q)};
          acc_d    = '0;
          mcand_d  = CostW'(dy_in);
          mplier_d = w_in;
          step_d   = '0;
          state_d  = ST_FINISH;
          if (in_grid) begin
            if (count_q != CountMax) count_d = count_q + 1'b1;
            if (occupied_i) begin
              if (blocked_q != CountMax) blocked_d = blocked_q + 1'b1;
            end else begin
              any_free_d = 1'b1;
              state_d    = ST_MUL_W;
            end
          end
        end
      end
      ST_MUL_W, ST_MUL_G, ST_MUL_S: begin
        // advance one multiplier bit
        acc_d    = step_acc;
        mcand_d  = {mcand_q[CostW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[GainW-1:1]};
        step_d   = step_q + 1'b1;
        if (step_last) begin
          if (state_q == ST_MUL_W) begin
            mcand_d  = step_acc + CostW'(dx_q);
            mplier_d = goal_gain_q;
            acc_d    = '0;
            state_d  = ST_MUL_G;
          end else if (state_q == ST_MUL_G) begin
            mcand_d  = CostW'(sxy_q);
            mplier_d = smooth_gain_q;
            state_d  = ST_MUL_S;
          end else begin
            state_d  = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        // keep the lowest cost, later cell wins a tie
        if (acc_q <= min_cost_q) begin
          min_cost_d = acc_q;
          min_x_d    = x_q;
          min_y_d    = y_q;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_ready_i) begin
          // emit the word and clear the scan
          out_valid_d = 1'b1;
          best_x_d    = any_free_q ? min_x_q : '0;
          best_y_d    = any_free_q ? min_y_q : '0;
          best_cost_d = any_free_q ? min_cost_q : '0;
          found_d     = any_free_q;
          class_d     = class_now;
          min_cost_d  = CostInit;
          min_x_d     = '0;
          min_y_d     = '0;
          any_free_d  = 1'b0;
          blocked_d   = '0;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_cost_q  <= CostInit;
      min_x_q     <= '0;
      min_y_q     <= '0;
      any_free_q  <= 1'b0;
      blocked_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_cost_q  <= min_cost_d;
      min_x_q     <= min_x_d;
      min_y_q     <= min_y_d;
      any_free_q  <= any_free_d;
      blocked_q   <= blocked_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      last_q      <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    y_q         <= y_d;
    dx_q        <= dx_d;
    sxy_q       <= sxy_d;
    acc_q       <= acc_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    best_x_q    <= best_x_d;
    best_y_q    <= best_y_d;
    best_cost_q <= best_cost_d;
    found_q     <= found_d;
    class_q     <= class_d;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q      <= 5'd0;
      goal_y_q      <= 5'd9;
      centre_x_q    <= 5'd14;
      centre_y_q    <= 5'd9;
      goal_gain_q   <= 4'd10;
      smooth_gain_q <= 4'd9;
      up_weight_q   <= 4'd5;
      down_weight_q <= 4'd10;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_GOAL_X:      goal_x_q      <= cfg_wdata_i;
        REG_GOAL_Y:      goal_y_q      <= cfg_wdata_i;
        REG_CENTRE_X:    centre_x_q    <= cfg_wdata_i;
        REG_CENTRE_Y:    centre_y_q    <= cfg_wdata_i;
        REG_GOAL_GAIN:   goal_gain_q   <= cfg_wdata_i[GainW-1:0];
        REG_SMOOTH_GAIN: smooth_gain_q <= cfg_wdata_i[GainW-1:0];
        REG_UP_WEIGHT:   up_weight_q   <= cfg_wdata_i[GainW-1:0];
        REG_DOWN_WEIGHT: down_weight_q <= cfg_wdata_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign best_x_o          = best_x_q;
  assign best_y_o          = best_y_q;
  assign best_cost_o       = best_cost_q;
  assign found_o           = found_q;
  assign occupancy_class_o = class_q;

endmodule

// ----- tb/cost_select_checker.sv -----
`timescale 1ns / 100ps
module cost_select_checker
  import hmccs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CoordW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [CoordW-1:0] cell_x_i,
  input  logic [CoordW-1:0] cell_y_i,
  input  logic              occupied_i,
  input  logic              last_cell_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CoordW-1:0] best_x_i,
  input  logic [CoordW-1:0] best_y_i,
  input  logic [CostW-1:0]  best_cost_i,
  input  logic              found_i,
  input  logic [1:0]        occupancy_class_i,
  output int                pending_o,
  output int                err_cnt_o
);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CostW-1:0]  cost;
    logic              found;
    occ_class_e        cls;
  } scan_result_t;

  // Scan results still owed by the block, oldest first
  scan_result_t scan_result_q[$];

  // Register copies
  logic [CoordW-1:0] goal_x_q, goal_y_q, centre_x_q, centre_y_q;
  logic [GainW-1:0]  goal_gain_q, smooth_gain_q, up_w_q, down_w_q;

  // Running scan state
  logic [CostW-1:0]  low_cost_q;
  logic [CoordW-1:0] low_x_q, low_y_q;
  logic              free_seen_q;
  logic [CountW-1:0] blocked_q, counted_q;

  int errs;

  function automatic int unsigned coord_dist(input logic [CoordW-1:0] a,
                                             input logic [CoordW-1:0] b);
    return (a >= b) ? int'(a - b) : int'(b - a);
  endfunction

  // Weighted goal distance plus smoothing distance, cut to the cost width
  function automatic logic [CostW-1:0] cell_cost(input logic [CoordW-1:0] x,
                                                 input logic [CoordW-1:0] y);
    int unsigned row_w, goal_term, smooth_term, total;
    row_w       = 32'((y >= goal_y_q) ? up_w_q : down_w_q);
    goal_term   = coord_dist(goal_x_q, x) + row_w * coord_dist(goal_y_q, y);
    smooth_term = coord_dist(x, centre_x_q) + coord_dist(y, centre_y_q);
    total       = 32'(goal_gain_q) * goal_term + 32'(smooth_gain_q) * smooth_term;
    return total[CostW-1:0];
  endfunction

  function automatic void clear_scan();
    low_cost_q  = CostInit;
    low_x_q     = '0;
    low_y_q     = '0;
    free_seen_q = 1'b0;
    blocked_q   = '0;
    counted_q   = '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want, made;
    logic [CostW-1:0] cost;
    if (!rst_ni) begin
      goal_x_q      = 5'd0;
      goal_y_q      = 5'd9;
      centre_x_q    = 5'd14;
      centre_y_q    = 5'd9;
      goal_gain_q   = 4'd10;
      smooth_gain_q = 4'd9;
      up_w_q        = 4'd5;
      down_w_q      = 4'd10;
      clear_scan();
      scan_result_q.delete();
      errs = 0;
    end else begin
      // Check a result word against the oldest owed result
      if (out_valid_i && out_ready_i) begin
        if (scan_result_q.size() == 0) begin
          $error("result word with nothing owed: best_x %0d best_y %0d cost %0d",
                 best_x_i, best_y_i, best_cost_i);
          errs++;
        end else begin
          want = scan_result_q.pop_front();
          if (best_x_i !== want.x) begin
            $error("best_x: expected %0d, got %0d", want.x, best_x_i);
            errs++;
          end
          if (best_y_i !== want.y) begin
            $error("best_y: expected %0d, got %0d", want.y, best_y_i);
            errs++;
          end
          if (best_cost_i !== want.cost) begin
            $error("best_cost: expected %0d, got %0d", want.cost, best_cost_i);
            errs++;
          end
          if (found_i !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found_i);
            errs++;
          end
          if (occupancy_class_i !== want.cls) begin
            $error("occupancy_class: expected %0d, got %0d", want.cls,
                   occupancy_class_i);
            errs++;
          end
        end
      end

      // Advance the scan on an accepted cell word
      if (in_valid_i && in_ready_i) begin
        if (cell_x_i < GRID_COLS && cell_y_i < GRID_ROWS) begin
          if (counted_q != CountMax) counted_q++;
          if (occupied_i) begin
            if (blocked_q != CountMax) blocked_q++;
          end else begin
            cost = cell_cost(cell_x_i, cell_y_i);
            // later cell wins a tie
            if (cost <= low_cost_q) begin
              low_cost_q = cost;
              low_x_q    = cell_x_i;
              low_y_q    = cell_y_i;
            end
            free_seen_q = 1'b1;
          end
        end
        if (last_cell_i) begin
          made.found = free_seen_q;
          made.x     = free_seen_q ? low_x_q : '0;
          made.y     = free_seen_q ? low_y_q : '0;
          made.cost  = free_seen_q ? low_cost_q : '0;
          if (blocked_q == 0) made.cls = OCC_EMPTY;
          else if (blocked_q == counted_q) made.cls = OCC_FULL;
          else made.cls = OCC_PARTIAL;
          scan_result_q.push_back(made);
          clear_scan();
        end
      end

      // Track register writes; every index is a register
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_GOAL_X:      goal_x_q = cfg_wdata_i;
          REG_GOAL_Y:      goal_y_q = cfg_wdata_i;
          REG_CENTRE_X:    centre_x_q = cfg_wdata_i;
          REG_CENTRE_Y:    centre_y_q = cfg_wdata_i;
          REG_GOAL_GAIN:   goal_gain_q = cfg_wdata_i[GainW-1:0];
          REG_SMOOTH_GAIN: smooth_gain_q = cfg_wdata_i[GainW-1:0];
          REG_UP_WEIGHT:   up_w_q = cfg_wdata_i[GainW-1:0];
          REG_DOWN_WEIGHT: down_w_q = cfg_wdata_i[GainW-1:0];
          default: ;
        endcase
      end
    end
    pending_o <= scan_result_q.size();
    err_cnt_o <= errs;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top
  import hmccs_pkg::*;
();

  localparam int unsigned RandomCells   = 450;
  localparam int unsigned PhaseCells    = 60;
  localparam int unsigned SettleCycles  = 30;
  localparam int unsigned StallLimit    = 2000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [2:0]        cfg_idx_i;
  logic [CoordW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [CoordW-1:0] cell_x_i;
  logic [CoordW-1:0] cell_y_i;
  logic              occupied_i;
  logic              last_cell_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CoordW-1:0] best_x_o;
  logic [CoordW-1:0] best_y_o;
  logic [CostW-1:0]  best_cost_o;
  logic              found_o;
  logic [1:0]        occupancy_class_o;

  int          pending;
  int          err_cnt;
  logic        calm = 1'b0;
  int unsigned next_gap = 0;
  int unsigned stall_cycles = 0;
  logic [CoordW-1:0] prev_x = '0, prev_y = '0;

  histogram_min_cost_cell_select dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .cell_x_i, .cell_y_i, .occupied_i, .last_cell_i,
    .out_valid_o, .out_ready_i, .best_x_o, .best_y_o, .best_cost_o, .found_o,
    .occupancy_class_o
  );

  cost_select_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i (in_ready_o),
    .cell_x_i, .cell_y_i, .occupied_i, .last_cell_i,
    .out_valid_i (out_valid_o), .out_ready_i,
    .best_x_i (best_x_o), .best_y_i (best_y_o), .best_cost_i (best_cost_o),
    .found_i (found_o), .occupancy_class_i (occupancy_class_o),
    .pending_o (pending), .err_cnt_o (err_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, a few long; none while calm
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly random coordinates, some at the edges, some repeating the last cell
  function automatic logic [CoordW-1:0] pick_coord(input logic [CoordW-1:0] prev);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return CoordW'($urandom_range(0, 31));
    if (r < 85) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return prev;
  endfunction

  // Send one cell word; lower valid after it if the next word is not back to back
  task automatic send_cell(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                           input logic occ, input logic last);
    repeat (next_gap) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    cell_x_i    <= x;
    cell_y_i    <= y;
    occupied_i  <= occ;
    last_cell_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    next_gap = pick_gap();
    if (next_gap != 0) in_valid_i <= 1'b0;
  endtask

  task automatic stop_cells();
    in_valid_i <= 1'b0;
    next_gap = 0;
  endtask

  // Wait for every owed result, then let the block go quiet
  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CoordW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [CoordW-1:0] gx, input logic [CoordW-1:0] gy,
                           input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                           input logic [CoordW-1:0] gg, input logic [CoordW-1:0] sg,
                           input logic [CoordW-1:0] uw, input logic [CoordW-1:0] dw);
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_GOAL_GAIN, gg);
    write_reg(REG_SMOOTH_GAIN, sg);
    write_reg(REG_UP_WEIGHT, uw);
    write_reg(REG_DOWN_WEIGHT, dw);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: ready high for a while, then stall for a gap
  initial begin
    int unsigned hold;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      hold = $urandom_range(1, 8);
      repeat (hold) @(posedge clk_i);
      hold = pick_gap();
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == StallLimit) begin
      $display("histogram_min_cost_cell_select test failed");
      $finish;
    end
  end

  initial begin
    int unsigned random_cells, phase_cells, len, occ_pct, r;
    logic [CoordW-1:0] x, y;
    random_cells = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_GOAL_X;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    cell_x_i    <= '0;
    cell_y_i    <= '0;
    occupied_i  <= 1'b0;
    last_cell_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: single free cell, single occupied cell, mixed scan
    send_cell(5'd0, 5'd0, 1'b0, 1'b1);
    send_cell(5'd31, 5'd31, 1'b1, 1'b1);
    send_cell(5'd31, 5'd0, 1'b0, 1'b0);
    send_cell(5'd0, 5'd31, 1'b1, 1'b0);
    send_cell(5'd0, 5'd9, 1'b0, 1'b0);
    send_cell(5'd31, 5'd31, 1'b0, 1'b1);
    stop_cells();
    settle();

    // Smoothing term only: equal costs, later cell must win
    write_all(5'd0, 5'd9, 5'd14, 5'd9, 5'd0, 5'd1, 5'd5, 5'd10);
    send_cell(5'd13, 5'd9, 1'b0, 1'b0);
    send_cell(5'd15, 5'd9, 1'b0, 1'b0);
    send_cell(5'd14, 5'd10, 1'b1, 1'b0);
    send_cell(5'd14, 5'd8, 1'b0, 1'b1);
    stop_cells();
    settle();

    // All registers zero: every free cell costs nothing
    write_all('0, '0, '0, '0, '0, '0, '0, '0);
    send_cell(5'd7, 5'd3, 1'b0, 1'b0);
    send_cell(5'd30, 5'd20, 1'b0, 1'b0);
    send_cell(5'd2, 5'd2, 1'b1, 1'b1);
    stop_cells();
    settle();

    // All ones written: largest cost, goal row edge for the weight choice
    write_all('1, '1, '1, '1, '1, '1, '1, '1);
    send_cell(5'd0, 5'd0, 1'b0, 1'b0);
    send_cell(5'd31, 5'd30, 1'b0, 1'b0);
    send_cell(5'd31, 5'd31, 1'b0, 1'b0);
    send_cell(5'd31, 5'd31, 1'b1, 1'b1);
    stop_cells();
    settle();

    // Random phases: new settings, then scans of random length and density
    while (random_cells < RandomCells) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        write_all('0, '1, '0, '1, '1, '0, '1, '0);
      end else if (r == 1) begin
        write_all('1, '0, '1, '0, '0, '1, '0, '1);
      end else begin
        write_all(CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
                  CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
                  CoordW'($urandom), CoordW'($urandom));
      end
      phase_cells = 0;
      while (phase_cells < PhaseCells && random_cells < RandomCells) begin
        calm = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 12);
        else if (r < 95) len = $urandom_range(13, 40);
        else len = $urandom_range(60, 150);
        // cap the scan at the cells still to send
        if (len > RandomCells - random_cells) len = RandomCells - random_cells;
        r = $urandom_range(0, 9);
        if (r < 2) occ_pct = 0;
        else if (r == 2) occ_pct = 100;
        else occ_pct = $urandom_range(10, 90);
        for (int unsigned i = 0; i < len; i++) begin
          x = pick_coord(prev_x);
          y = pick_coord(prev_y);
          prev_x = x;
          prev_y = y;
          send_cell(x, y, $urandom_range(0, 99) < occ_pct, i == len - 1);
        end
        phase_cells += len;
        random_cells += len;
      end
      calm = 1'b0;
      stop_cells();
      settle();
    end

    if (err_cnt == 0 && pending == 0) begin
      $display("histogram_min_cost_cell_select test passed");
    end else begin
      $display("histogram_min_cost_cell_select test failed");
    end
    $finish;
  end

endmodule
